[rtl/core/atis_pkg.sv]
// Shared types and constants for the packed-list core.
// Payload structs, operation and status codes, controller/datapath command and status.
`default_nettype none

package atis_pkg;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 4;
  localparam int LEN_W   = 5;
  localparam int SUM_W   = 36;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] operand_value;
  } atis_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] result_value;
    logic [FOUND_W-1:0]      found_position;
    logic [LEN_W-1:0]        list_length;
    logic signed [SUM_W-1:0] total;
  } atis_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // latch the request, set up pointer and move count
    logic rd;          // read entry at pointer, step pointer
    logic mv;          // write last read entry one slot over
    logic put;         // write operand at request position
    logic grab;        // capture read entry as result value
    logic hit;         // record search match position
    logic miss;        // mark search miss
    logic done;        // mark success
    logic commit_ins;  // grow list, add operand to sum
    logic commit_del;  // shrink list, subtract read entry from sum
    logic commit_set;  // replace read entry by operand in sum
    logic emit;        // load the output register
  } atis_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_ok;
    logic              idx_ok;
    logic              rem_zero;
    logic              match;
  } atis_stat_t;

endpackage

`default_nettype wire

[rtl/core/array_table_insert_delete_search_core.sv]
// Packed list of up to min(capacity, DEPTH) signed 32-bit entries with insert, delete,
// search, get and set; every result carries the list length and the exact running sum.
// Entries live in a one-read, one-write memory and insert, delete and search move or
// compare one entry per cycle through it. An item is loaded and checked, then reads the
// stored entries it moves or scans (one for get and set, none for a rejected request or
// a search of an empty list); an insert or set then writes its operand, and the result is emitted.
// A result that cannot leave the output register holds the next one in its last cycle.
// One request is in flight at a time; a new request is taken while the previous result
// still waits in the output register.
// Depends on atis_pkg, atis_ctrl and atis_dp.
`default_nettype none

module array_table_insert_delete_search_core
  import atis_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire atis_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output atis_out_t             out_data
);

  atis_cmd_t  cmd;
  atis_stat_t stat;

  atis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  atis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

[rtl/core/atis_dp.sv]
// Datapath of the packed-list core: entry memory, length, running sum, result registers.
// Depends on atis_pkg; driven by commands from atis_ctrl.
`default_nettype none

module atis_dp
  import atis_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  input  wire atis_in_t         in_data,
  input  wire atis_cmd_t        cmd,
  output atis_stat_t            stat,
  output atis_out_t             out_data
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]        capacity;
  logic [CW-1:0]           count;
  logic signed [SUM_W-1:0] run_sum;

  logic [KIND_W-1:0]       kind_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] key_q;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           laddr;
  logic [CW-1:0]           rem;
  logic signed [VAL_W-1:0] rdata;

  logic [STAT_W-1:0]       res_status;
  logic signed [VAL_W-1:0] res_value;
  logic [FOUND_W-1:0]      res_found;

  logic [CW-1:0]           in_pos;
  logic [CW-1:0]           laddr_inc;
  logic [CW-1:0]           laddr_dec;
  logic [AW-1:0]           mv_idx;
  logic [AW-1:0]           put_idx;
  logic [CMPW-1:0]         count_x;
  logic [CMPW-1:0]         cap_x;
  logic [CMPW-1:0]         pos_x;
  logic signed [SUM_W-1:0] key_x;
  logic signed [SUM_W-1:0] rdata_x;

  assign in_pos    = CW'(in_data.position);
  assign laddr_inc = laddr + CW'(1);
  assign laddr_dec = laddr - CW'(1);
  // Insert moves entries up, delete moves them down.
  assign mv_idx    = (kind_q == KIND_INSERT) ? laddr_inc[AW-1:0] : laddr_dec[AW-1:0];
  assign put_idx   = AW'(pos_q);

  assign count_x = CMPW'(count);
  assign cap_x   = CMPW'(capacity);
  assign pos_x   = CMPW'(pos_q);
  assign key_x   = {{(SUM_W-VAL_W){key_q[VAL_W-1]}}, key_q};
  assign rdata_x = {{(SUM_W-VAL_W){rdata[VAL_W-1]}}, rdata};

  assign stat.kind     = kind_q;
  assign stat.ins_ok   = (count_x < cap_x) && (count < CW'(DEPTH)) && (pos_x <= count_x);
  assign stat.idx_ok   = pos_x < count_x;
  assign stat.rem_zero = rem == '0;
  assign stat.match    = rdata == key_q;

  always_ff @(posedge clk) begin
    if (cmd.mv) begin
      mem[mv_idx] <= rdata;
    end else if (cmd.put) begin
      mem[put_idx] <= key_q;
    end
    if (cmd.rd) begin
      rdata <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_data.kind;
      pos_q  <= in_data.position;
      key_q  <= in_data.operand_value;
      unique case (in_data.kind)
        KIND_INSERT: begin
          ptr <= count - CW'(1);
          rem <= count - in_pos;
        end
        KIND_DELETE: begin
          ptr <= in_pos;
          rem <= count - in_pos;
        end
        KIND_SEARCH: begin
          ptr <= '0;
          rem <= count;
        end
        default: begin
          ptr <= in_pos;
          rem <= CW'(1);
        end
      endcase
    end else if (cmd.rd) begin
      laddr <= ptr;
      rem   <= rem - CW'(1);
      ptr   <= (kind_q == KIND_INSERT) ? ptr - CW'(1) : ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= ST_REJECT;
      res_value  <= '0;
      res_found  <= '0;
    end else begin
      if (cmd.done || cmd.commit_ins || cmd.commit_del || cmd.commit_set) begin
        res_status <= ST_DONE;
      end
      if (cmd.miss) begin
        res_status <= ST_MISS;
      end
      if (cmd.hit) begin
        res_status <= ST_DONE;
        res_found  <= FOUND_W'(laddr);
      end
      if (cmd.grab) begin
        res_value <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      run_sum  <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (cmd.commit_ins) begin
        count   <= count + CW'(1);
        run_sum <= run_sum + key_x;
      end else if (cmd.commit_del) begin
        count   <= count - CW'(1);
        run_sum <= run_sum - rdata_x;
      end else if (cmd.commit_set) begin
        run_sum <= run_sum + key_x - rdata_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status         <= res_status;
      out_data.result_value   <= res_value;
      out_data.found_position <= res_found;
      out_data.list_length    <= LEN_W'(count);
      out_data.total          <= run_sum;
    end
  end

endmodule

`default_nettype wire

[rtl/core/atis_ctrl.sv]
// Controller of the packed-list core: sequences shifts, scans and result hand-off.
// Depends on atis_pkg; commands atis_dp and owns the channel handshakes.
`default_nettype none

module atis_ctrl
  import atis_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire atis_stat_t stat,
  output atis_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_MOVE,
    S_INS_PUT,
    S_DEL_FIRST,
    S_DEL_MOVE,
    S_SRCH,
    S_GET_TAKE,
    S_SET_WR,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FIN;
        unique case (stat.kind)
          KIND_INSERT: begin
            if (stat.ins_ok) begin
              if (stat.rem_zero) begin
                state_next = S_INS_PUT;
              end else begin
                cmd.rd     = 1'b1;
                state_next = S_INS_MOVE;
              end
            end
          end
          KIND_DELETE: begin
            if (stat.idx_ok) begin
              cmd.rd     = 1'b1;
              state_next = S_DEL_FIRST;
            end
          end
          KIND_SEARCH: begin
            if (stat.rem_zero) begin
              cmd.miss = 1'b1;
            end else begin
              cmd.rd     = 1'b1;
              state_next = S_SRCH;
            end
          end
          KIND_GET: begin
            if (stat.idx_ok) begin
              cmd.rd     = 1'b1;
              state_next = S_GET_TAKE;
            end
          end
          KIND_SET: begin
            if (stat.idx_ok) begin
              cmd.rd     = 1'b1;
              state_next = S_SET_WR;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_INS_MOVE: begin
        cmd.mv = 1'b1;
        if (stat.rem_zero) begin
          state_next = S_INS_PUT;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_INS_PUT: begin
        cmd.put        = 1'b1;
        cmd.commit_ins = 1'b1;
        state_next     = S_FIN;
      end
      S_DEL_FIRST: begin
        // Read data holds the removed entry; any later entries still to move down.
        cmd.grab       = 1'b1;
        cmd.commit_del = 1'b1;
        if (stat.rem_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_DEL_MOVE;
        end
      end
      S_DEL_MOVE: begin
        cmd.mv = 1'b1;
        if (stat.rem_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_SRCH: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_FIN;
        end else if (stat.rem_zero) begin
          cmd.miss   = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_GET_TAKE: begin
        cmd.grab   = 1'b1;
        cmd.done   = 1'b1;
        state_next = S_FIN;
      end
      S_SET_WR: begin
        cmd.put        = 1'b1;
        cmd.commit_set = 1'b1;
        state_next     = S_FIN;
      end
      S_FIN: begin
        // Hold until the previous transaction has left the output register.
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
